@@ design/escaped_frame_receiver_checksum_top_macros.svh @@
// Assertion macros for the escaped frame receiver.
// Used by escaped_frame_receiver_checksum_top; no other dependencies.
`ifndef ESCAPED_FRAME_RECEIVER_CHECKSUM_TOP_MACROS_SVH
`define ESCAPED_FRAME_RECEIVER_CHECKSUM_TOP_MACROS_SVH

// Condition must hold at every edge outside reset.
`define EFR_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("efr assertion failed");

// Antecedent implies consequent in the same cycle.
`define EFR_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("efr assertion failed");

`endif

@@ design/efr_pkg.sv @@
// Package for the escaped frame receiver: byte codes, frame sizes, types.
// No dependencies.
package efr_pkg;

   typedef logic [7:0] byte_type;
   typedef logic [2:0] count_type;

   localparam byte_type  FLAG_BYTE   = 8'h7E;
   localparam byte_type  ESC_BYTE    = 8'h7D;
   localparam byte_type  ESC_XOR     = 8'h20;
   localparam int        PAYLOAD_LEN = 5;
   localparam count_type SUM_POS     = count_type'(PAYLOAD_LEN);

endpackage

@@ design/escaped_frame_receiver_checksum_top.sv @@
// Escaped frame receiver: flag hunt, escape removal, 5-byte payload, additive checksum.
// Depends on efr_pkg and escaped_frame_receiver_checksum_top_macros.svh.
//
//   channel | direction | ports                                   | beat
//   req     | in        | req_valid, req_ready, req_rx_byte       | one raw serial byte
//   rsp     | out       | rsp_valid, rsp_ready, rsp_payload_b1..5,| one decoded frame
//           |           | rsp_sum_received, rsp_sum_match         |
//
// One byte per cycle while req_ready is high; a frame result appears in the cycle after its checksum byte.
// Frame state updates on the accepting edge; the result sits in an output register.
// req_ready drops only while a result is held and rsp_ready is low.
// Synchronous reset returns to flag hunting and empties the output register.
`include "escaped_frame_receiver_checksum_top_macros.svh"

module escaped_frame_receiver_checksum_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  efr_pkg::byte_type req_rx_byte,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output efr_pkg::byte_type rsp_payload_b1,
   output efr_pkg::byte_type rsp_payload_b2,
   output efr_pkg::byte_type rsp_payload_b3,
   output efr_pkg::byte_type rsp_payload_b4,
   output efr_pkg::byte_type rsp_payload_b5,
   output efr_pkg::byte_type rsp_sum_received,
   output logic              rsp_sum_match
);
   import efr_pkg::*;

   logic      in_frame_ff, in_frame_in;
   logic      escape_ff, escape_in;
   count_type count_ff, count_in;
   byte_type  sum_ff, sum_in;
   byte_type  store_ff [PAYLOAD_LEN];
   logic      rsp_valid_ff, rsp_valid_in;
   byte_type  rsp_pl_ff [PAYLOAD_LEN];
   byte_type  rsp_sum_ff;
   logic      rsp_match_ff;

   logic     accept;
   byte_type data;
   logic     take;
   logic     store_wr;
   logic     emit;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign data      = escape_ff ? (req_rx_byte ^ ESC_XOR) : req_rx_byte;
   assign take      = accept && in_frame_ff && (req_rx_byte != ESC_BYTE);
   assign store_wr  = take && (count_ff < SUM_POS);
   assign emit      = take && (count_ff >= SUM_POS);

   always_comb begin
      in_frame_in = in_frame_ff;
      escape_in   = escape_ff;
      count_in    = count_ff;
      sum_in      = sum_ff;
      if (accept) begin
         if (!in_frame_ff) begin
            if (req_rx_byte == FLAG_BYTE) begin
               in_frame_in = 1'b1;
               escape_in   = 1'b0;
               count_in    = '0;
               sum_in      = '0;
            end
         end else if (req_rx_byte == ESC_BYTE) begin
            escape_in = 1'b1;
         end else if (store_wr) begin
            escape_in = 1'b0;
            count_in  = count_ff + count_type'(1);
            sum_in    = sum_ff + data;
         end else begin
            in_frame_in = 1'b0;
            escape_in   = 1'b0;
            count_in    = '0;
            sum_in      = '0;
         end
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff  <= 1'b0;
         escape_ff    <= 1'b0;
         count_ff     <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_frame_ff  <= in_frame_in;
         escape_ff    <= escape_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < PAYLOAD_LEN; i++) begin
         if (store_wr && (count_ff == count_type'(i))) begin
            store_ff[i] <= data;
         end
      end
      if (emit) begin
         for (int i = 0; i < PAYLOAD_LEN; i++) begin
            rsp_pl_ff[i] <= store_ff[i];
         end
         rsp_sum_ff   <= data;
         rsp_match_ff <= (sum_ff == data);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_payload_b1   = rsp_pl_ff[0];
   assign rsp_payload_b2   = rsp_pl_ff[1];
   assign rsp_payload_b3   = rsp_pl_ff[2];
   assign rsp_payload_b4   = rsp_pl_ff[3];
   assign rsp_payload_b5   = rsp_pl_ff[4];
   assign rsp_sum_received = rsp_sum_ff;
   assign rsp_sum_match    = rsp_match_ff;

   // hunting state carries no partial frame
   `EFR_ASSERT_IMPL(a_hunt_clean, clock, reset, !in_frame_ff,
      (count_ff == '0) && !escape_ff && (sum_ff == '0))
   // count never passes the checksum position
   `EFR_ASSERT_ALWAYS(a_count_range, clock, reset, count_ff <= SUM_POS)
   // a result only follows a checksum byte of a full frame
   `EFR_ASSERT_IMPL(a_emit_src, clock, reset, emit,
      in_frame_ff && (count_ff == SUM_POS) && req_ready)
   // a frame end always leaves the receiver hunting
   `EFR_ASSERT_IMPL(a_emit_hunt, clock, reset, $past(emit) && !$past(reset),
      rsp_valid_ff && !in_frame_ff)

endmodule

@@ sim/tb_escaped_frame_receiver_checksum_top.sv @@
// Testbench for escaped_frame_receiver_checksum_top: byte-stream driver, frame monitor
// and an in-bench frame decoder that predicts every result. Depends on efr_pkg and the RTL.
module tb_escaped_frame_receiver_checksum_top;
   import efr_pkg::*;

   localparam int RANDOM_BYTES = 1500;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int LONG_HOLD    = 400;

   typedef struct packed {
      logic [4:0][7:0] pay;
      byte_type        sum;
      logic            match;
   } decoded_frame_type;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_ready;
   byte_type req_rx_byte = '0;
   logic     rsp_valid;
   logic     rsp_ready = 1'b0;
   byte_type rsp_payload_b1, rsp_payload_b2, rsp_payload_b3, rsp_payload_b4;
   byte_type rsp_payload_b5, rsp_sum_received;
   logic     rsp_sum_match;

   byte_type          rx_stream[$];
   decoded_frame_type frames_expected[$];
   int                stream_len = 0;
   int                bytes_taken = 0;
   int                frames_seen = 0;
   int                frame_errors = 0;
   int                send_gap = 0;
   int                ready_hold = 0;
   int                cycle_count = 0;
   logic              calm = 1'b0;

   // decoder state
   logic      dec_in_frame = 1'b0;
   logic      dec_esc = 1'b0;
   count_type dec_count = '0;
   byte_type  dec_sum = '0;
   byte_type  dec_store [PAYLOAD_LEN];

   escaped_frame_receiver_checksum_top i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_payload_b1  (rsp_payload_b1),
      .rsp_payload_b2  (rsp_payload_b2),
      .rsp_payload_b3  (rsp_payload_b3),
      .rsp_payload_b4  (rsp_payload_b4),
      .rsp_payload_b5  (rsp_payload_b5),
      .rsp_sum_received(rsp_sum_received),
      .rsp_sum_match   (rsp_sum_match)
   );

   always #2 clock = ~clock;

   task automatic decode_rx_byte(input byte_type b);
      byte_type          d;
      decoded_frame_type f;
      if (!dec_in_frame) begin
         if (b == FLAG_BYTE) begin
            dec_in_frame = 1'b1;
            dec_esc = 1'b0;
            dec_count = '0;
            dec_sum = '0;
         end
      end else if (b == ESC_BYTE) begin
         dec_esc = 1'b1;
      end else begin
         d = dec_esc ? (b ^ ESC_XOR) : b;
         dec_esc = 1'b0;
         if (dec_count < SUM_POS) begin
            dec_store[dec_count] = d;
            dec_sum = dec_sum + d;
            dec_count = dec_count + 1'b1;
         end else begin
            for (int k = 0; k < PAYLOAD_LEN; k++) f.pay[k] = dec_store[k];
            f.sum = d;
            f.match = (dec_sum == d);
            frames_expected.push_back(f);
            dec_in_frame = 1'b0;
            dec_esc = 1'b0;
            dec_count = '0;
            dec_sum = '0;
         end
      end
   endtask

   task automatic put_raw(input byte_type b);
      rx_stream.push_back(b);
      stream_len++;
   endtask

   // one data value, escaped when it must be and sometimes when it need not be
   task automatic put_data(input byte_type d);
      if (d == ESC_BYTE || (d != (ESC_BYTE ^ ESC_XOR) && $urandom_range(0, 7) == 0)) begin
         put_raw(ESC_BYTE);
         put_raw(d ^ ESC_XOR);
      end else begin
         put_raw(d);
      end
   endtask

   function automatic byte_type pick_data();
      case ($urandom_range(0, 11))
         0: pick_data = FLAG_BYTE;
         1: pick_data = ESC_BYTE;
         2: pick_data = FLAG_BYTE ^ ESC_XOR;
         3: pick_data = ESC_BYTE ^ ESC_XOR;
         4: pick_data = 8'h00;
         5: pick_data = 8'hFF;
         default: pick_data = byte_type'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic put_frame(input bit bad_sum);
      byte_type d;
      byte_type s;
      s = '0;
      put_raw(FLAG_BYTE);
      for (int k = 0; k < PAYLOAD_LEN; k++) begin
         d = pick_data();
         s = s + d;
         put_data(d);
      end
      if (bad_sum) s = s ^ byte_type'($urandom_range(1, 255));
      put_data(s);
   endtask

   initial begin
      int kind;
      int n;
      // noise while hunting, escape there included
      put_raw(ESC_BYTE);
      put_raw(8'h00);
      // all-zero frame
      put_raw(FLAG_BYTE);
      repeat (6) put_raw(8'h00);
      // escaped flag, raw flag as data, escaped escape, double escape, bad sum
      put_raw(FLAG_BYTE);
      put_raw(ESC_BYTE);
      put_raw(FLAG_BYTE ^ ESC_XOR);
      put_raw(FLAG_BYTE);
      put_raw(ESC_BYTE);
      put_raw(ESC_BYTE ^ ESC_XOR);
      put_raw(8'hFF);
      put_raw(ESC_BYTE);
      put_raw(ESC_BYTE);
      put_raw(ESC_XOR);
      put_raw(8'h11);
      // all-ones frame, good sum
      put_raw(FLAG_BYTE);
      repeat (5) put_raw(8'hFF);
      put_raw(8'hFB);

      stream_len = 0;
      while (stream_len < RANDOM_BYTES) begin
         kind = $urandom_range(0, 9);
         if (kind < 8) begin
            put_frame($urandom_range(0, 4) == 0);
         end else if (kind == 8) begin
            // broken: flag and a partial frame, raw escapes and flags mixed in
            put_raw(FLAG_BYTE);
            n = $urandom_range(0, 5);
            repeat (n) begin
               case ($urandom_range(0, 3))
                  0: put_raw(ESC_BYTE);
                  1: put_raw(FLAG_BYTE);
                  default: put_raw(byte_type'($urandom_range(0, 255)));
               endcase
            end
         end else begin
            // line noise
            n = $urandom_range(1, 4);
            repeat (n) put_raw(byte_type'($urandom_range(0, 255)));
         end
      end
      n = rx_stream.size();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      wait (bytes_taken == n);
      wait (frames_expected.size() == 0);
      repeat (10) @(posedge clock);
      if (frames_expected.size() != 0) begin
         $display("frames still expected at end: %0d", frames_expected.size());
         frame_errors++;
      end
      if (frame_errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   always @(posedge clock) begin
      if ($urandom_range(0, 249) == 0) calm <= !calm;
   end

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = $urandom_range(0, 5);
      end else begin
         if (req_valid && req_ready) begin
            decode_rx_byte(req_rx_byte);
            bytes_taken++;
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (rx_stream.size() > 0) begin
               req_valid <= 1'b1;
               req_rx_byte <= rx_stream.pop_front();
               send_gap = calm ? 0 : $urandom_range(0, 5);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      decoded_frame_type got;
      decoded_frame_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         ready_hold = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.pay = {rsp_payload_b5, rsp_payload_b4, rsp_payload_b3,
                       rsp_payload_b2, rsp_payload_b1};
            got.sum = rsp_sum_received;
            got.match = rsp_sum_match;
            if (frames_expected.size() == 0) begin
               frame_errors++;
               if (frame_errors <= 10)
                  $display("unexpected frame: pay=%h sum=%h match=%b",
                           got.pay, got.sum, got.match);
            end else begin
               want = frames_expected.pop_front();
               if (got.pay !== want.pay || got.sum !== want.sum
                   || got.match !== want.match) begin
                  frame_errors++;
                  if (frame_errors <= 10)
                     $display("frame %0d: exp pay=%h sum=%h match=%b, got pay=%h sum=%h match=%b",
                              frames_seen, want.pay, want.sum, want.match,
                              got.pay, got.sum, got.match);
               end
            end
            frames_seen++;
            // long back-pressure so the output register fills and req stalls
            if (frames_seen == 15 || frames_seen == 90) ready_hold = LONG_HOLD;
            else ready_hold = calm ? 0 : $urandom_range(0, 5);
         end
         if (ready_hold > 0) begin
            ready_hold--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Regression FAIL");
         $finish;
      end
   end

endmodule

@@ sim.f @@
+incdir+design
design/efr_pkg.sv
design/escaped_frame_receiver_checksum_top.sv
sim/tb_escaped_frame_receiver_checksum_top.sv
